[hdl/qau_pkg.sv]
package qau_pkg;

  localparam int DATA_W        = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 4;
  localparam int FRAC_BITS_DEF = 12;
  localparam int IN_DATA_W     = 8 * DATA_W;
  localparam int OUT_DATA_W    = 4 * DATA_W;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    FUNC_MUL  = 2'd0,
    FUNC_ROT  = 2'd1,
    FUNC_CONJ = 2'd2
  } func_t;

  typedef struct packed {
    fx_t  val;
    logic ovf;
  } sat_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } cross_adv_t;

  localparam acc_t SAT_MAX = acc_t'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam acc_t SAT_MIN = acc_t'(-(64'sd1 <<< (DATA_W - 1)));

  function automatic sat_t sat16(acc_t x);
    sat_t res;
    res.val = x[DATA_W-1:0];
    res.ovf = 1'b0;
    if (x > SAT_MAX) begin
      res.val = SAT_MAX[DATA_W-1:0];
      res.ovf = 1'b1;
    end else if (x < SAT_MIN) begin
      res.val = SAT_MIN[DATA_W-1:0];
      res.ovf = 1'b1;
    end
    return res;
  endfunction

endpackage

[hdl/quaternion_arithmetic_unit.sv]
// Pipelined Q4.12 quaternion unit: Hamilton product, rotation of a 3-vector by a
// quaternion, and conjugate. One word is accepted per cycle while in_tready is high;
// the five register stages are set by the rotation path, which runs two
// multiply-then-sum steps in series (u x v, then u x (u x v) together with
// w * (u x v)). Each stage stalls only when it is full and the stage after it
// cannot take its word, so gaps in the pipeline fill even while a finished
// result waits at the output.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [qau_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // r_w, r_x, r_y, r_z
  output logic [qau_pkg::OUT_DATA_W-1:0]   out_tdata,
  // overflow
  output logic                             out_tuser
);

  localparam int DW = qau_pkg::DATA_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5      = !v5_r || out_tready;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  qau_pkg::func_t in_func;
  qau_pkg::fx_t   in_aw, in_bw;
  qau_pkg::fx_t   in_a [3];
  qau_pkg::fx_t   in_b [3];

  always_comb begin
    in_func = qau_pkg::func_t'(in_tuser);
    in_aw   = in_tdata[DW-1:0];
    in_bw   = in_tdata[4*DW +: DW];
    for (int i = 0; i < 3; i++) begin
      in_a[i] = in_tdata[(i + 1) * DW +: DW];
      in_b[i] = in_tdata[(i + 5) * DW +: DW];
    end
  end

  // stage 1: all partial products
  qau_pkg::func_t func1_r;
  qau_pkg::fx_t   aw1_r;
  qau_pkg::fx_t   a1_r [3];
  qau_pkg::fx_t   b1_r [3];
  qau_pkg::prod_t p_ww_r;
  qau_pkg::prod_t p_wb_r [3];
  qau_pkg::prod_t p_aw_r [3];
  qau_pkg::prod_t p_ab_r [3][3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      func1_r <= in_func;
      aw1_r   <= in_aw;
      a1_r    <= in_a;
      b1_r    <= in_b;
      p_ww_r  <= qau_pkg::prod_t'(in_aw) * qau_pkg::prod_t'(in_bw);
      for (int i = 0; i < 3; i++) begin
        p_wb_r[i] <= qau_pkg::prod_t'(in_aw) * qau_pkg::prod_t'(in_b[i]);
        p_aw_r[i] <= qau_pkg::prod_t'(in_a[i]) * qau_pkg::prod_t'(in_bw);
        for (int j = 0; j < 3; j++) begin
          p_ab_r[i][j] <= qau_pkg::prod_t'(in_a[i]) * qau_pkg::prod_t'(in_b[j]);
        end
      end
    end
  end

  // stage 2: Hamilton sums and u x v
  qau_pkg::acc_t h_sum [4];
  qau_pkg::acc_t uv_sum [3];
  qau_pkg::fx_t  h_nxt [4];
  qau_pkg::fx_t  uv_nxt [3];
  logic          hovf_nxt, uvovf_nxt;

  always_comb begin
    qau_pkg::sat_t s;
    h_sum[0] = qau_pkg::acc_t'(p_ww_r) - qau_pkg::acc_t'(p_ab_r[0][0])
             - qau_pkg::acc_t'(p_ab_r[1][1]) - qau_pkg::acc_t'(p_ab_r[2][2]);
    h_sum[1] = qau_pkg::acc_t'(p_wb_r[0]) + qau_pkg::acc_t'(p_aw_r[0])
             + qau_pkg::acc_t'(p_ab_r[1][2]) - qau_pkg::acc_t'(p_ab_r[2][1]);
    h_sum[2] = qau_pkg::acc_t'(p_wb_r[1]) + qau_pkg::acc_t'(p_aw_r[1])
             + qau_pkg::acc_t'(p_ab_r[2][0]) - qau_pkg::acc_t'(p_ab_r[0][2]);
    h_sum[3] = qau_pkg::acc_t'(p_wb_r[2]) + qau_pkg::acc_t'(p_aw_r[2])
             + qau_pkg::acc_t'(p_ab_r[0][1]) - qau_pkg::acc_t'(p_ab_r[1][0]);
    uv_sum[0] = qau_pkg::acc_t'(p_ab_r[1][2]) - qau_pkg::acc_t'(p_ab_r[2][1]);
    uv_sum[1] = qau_pkg::acc_t'(p_ab_r[2][0]) - qau_pkg::acc_t'(p_ab_r[0][2]);
    uv_sum[2] = qau_pkg::acc_t'(p_ab_r[0][1]) - qau_pkg::acc_t'(p_ab_r[1][0]);
    hovf_nxt  = 1'b0;
    uvovf_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s        = qau_pkg::sat16(h_sum[i] >>> FRAC_BITS);
      h_nxt[i] = s.val;
      hovf_nxt = hovf_nxt | s.ovf;
    end
    for (int i = 0; i < 3; i++) begin
      s         = qau_pkg::sat16(uv_sum[i] >>> FRAC_BITS);
      uv_nxt[i] = s.val;
      uvovf_nxt = uvovf_nxt | s.ovf;
    end
  end

  qau_pkg::func_t func2_r;
  qau_pkg::fx_t   aw2_r;
  qau_pkg::fx_t   a2_r  [3];
  qau_pkg::fx_t   b2_r  [3];
  qau_pkg::fx_t   h2_r  [4];
  qau_pkg::fx_t   uv2_r [3];
  logic           hovf2_r, uvovf2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      func2_r  <= func1_r;
      aw2_r    <= aw1_r;
      a2_r     <= a1_r;
      b2_r     <= b1_r;
      h2_r     <= h_nxt;
      uv2_r    <= uv_nxt;
      hovf2_r  <= hovf_nxt;
      uvovf2_r <= uvovf_nxt;
    end
  end

  // stages 3 and 4: u x (u x v) and w * (u x v)
  qau_pkg::cross_adv_t cross_adv;
  qau_pkg::fx_t        uuv4 [3];
  logic                uuvovf4;

  assign cross_adv.mul = rdy3;
  assign cross_adv.sum = rdy4;

  qau_cross #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cross (
    .clk (clk),
    .adv (cross_adv),
    .p   (a2_r),
    .q   (uv2_r),
    .r   (uuv4),
    .ovf (uuvovf4)
  );

  qau_pkg::func_t func3_r, func4_r;
  qau_pkg::fx_t   aw3_r, aw4_r;
  qau_pkg::fx_t   a3_r [3];
  qau_pkg::fx_t   a4_r [3];
  qau_pkg::fx_t   b3_r [3];
  qau_pkg::fx_t   b4_r [3];
  qau_pkg::fx_t   h3_r [4];
  qau_pkg::fx_t   h4_r [4];
  logic           hovf3_r, hovf4_r, uvovf3_r, uvovf4_r;
  qau_pkg::prod_t wuv3_r [3];
  qau_pkg::prod_t wuv4_r [3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      func3_r  <= func2_r;
      aw3_r    <= aw2_r;
      a3_r     <= a2_r;
      b3_r     <= b2_r;
      h3_r     <= h2_r;
      hovf3_r  <= hovf2_r;
      uvovf3_r <= uvovf2_r;
      for (int i = 0; i < 3; i++) begin
        wuv3_r[i] <= qau_pkg::prod_t'(aw2_r) * qau_pkg::prod_t'(uv2_r[i]);
      end
    end
    if (rdy4) begin
      func4_r  <= func3_r;
      aw4_r    <= aw3_r;
      a4_r     <= a3_r;
      b4_r     <= b3_r;
      h4_r     <= h3_r;
      hovf4_r  <= hovf3_r;
      uvovf4_r <= uvovf3_r;
      for (int i = 0; i < 3; i++) begin
        wuv4_r[i] <= wuv3_r[i] >>> FRAC_BITS;
      end
    end
  end

  // stage 5: final combine and select
  qau_pkg::fx_t r_nxt [4];
  logic         ovf_nxt;

  always_comb begin
    qau_pkg::sat_t s;
    qau_pkg::acc_t t;
    for (int i = 0; i < 4; i++) begin
      r_nxt[i] = '0;
    end
    ovf_nxt = 1'b0;
    case (func4_r)
      qau_pkg::FUNC_MUL: begin
        r_nxt   = h4_r;
        ovf_nxt = hovf4_r;
      end
      qau_pkg::FUNC_ROT: begin
        ovf_nxt = uvovf4_r | uuvovf4;
        for (int i = 0; i < 3; i++) begin
          t = qau_pkg::acc_t'(b4_r[i])
            + ((qau_pkg::acc_t'(wuv4_r[i]) + qau_pkg::acc_t'(uuv4[i])) <<< 1);
          s            = qau_pkg::sat16(t);
          r_nxt[i + 1] = s.val;
          ovf_nxt      = ovf_nxt | s.ovf;
        end
      end
      qau_pkg::FUNC_CONJ: begin
        r_nxt[0] = aw4_r;
        for (int i = 0; i < 3; i++) begin
          s            = qau_pkg::sat16(-qau_pkg::acc_t'(a4_r[i]));
          r_nxt[i + 1] = s.val;
          ovf_nxt      = ovf_nxt | s.ovf;
        end
      end
      default: begin
        ovf_nxt = 1'b0;
      end
    endcase
  end

  qau_pkg::fx_t r5_r [4];
  logic         ovf5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      r5_r   <= r_nxt;
      ovf5_r <= ovf_nxt;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {r5_r[3], r5_r[2], r5_r[1], r5_r[0]};
  assign out_tuser  = ovf5_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n) !v1_r |-> in_tready)
    else $error("input refused while first stage is empty");

  a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> v2_r)
    else $error("stage 2 word lost during stall");

  a_hold_s4: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !rdy5) |=> (v4_r && $stable(uuvovf4)))
    else $error("stage 4 word changed during stall");
`endif

endmodule

[hdl/qau_cross.sv]
module qau_cross #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  qau_pkg::cross_adv_t adv,
  input  qau_pkg::fx_t        p [3],
  input  qau_pkg::fx_t        q [3],
  output qau_pkg::fx_t        r [3],
  output logic                ovf
);

  qau_pkg::prod_t m_pos_r [3];
  qau_pkg::prod_t m_neg_r [3];
  qau_pkg::fx_t   r_r     [3];
  logic           ovf_r;
  qau_pkg::fx_t   r_nxt   [3];
  logic           ovf_nxt;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      for (int i = 0; i < 3; i++) begin
        m_pos_r[i] <= qau_pkg::prod_t'(p[(i + 1) % 3]) * qau_pkg::prod_t'(q[(i + 2) % 3]);
        m_neg_r[i] <= qau_pkg::prod_t'(p[(i + 2) % 3]) * qau_pkg::prod_t'(q[(i + 1) % 3]);
      end
    end
  end

  always_comb begin
    qau_pkg::acc_t d;
    qau_pkg::sat_t s;
    ovf_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d        = (qau_pkg::acc_t'(m_pos_r[i]) - qau_pkg::acc_t'(m_neg_r[i])) >>> FRAC_BITS;
      s        = qau_pkg::sat16(d);
      r_nxt[i] = s.val;
      ovf_nxt  = ovf_nxt | s.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      r_r   <= r_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign r   = r_r;
  assign ovf = ovf_r;

endmodule

[bench/testbench.sv]
module testbench;

  localparam int FRAC = qau_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    qau_pkg::fx_t w;
    qau_pkg::fx_t x;
    qau_pkg::fx_t y;
    qau_pkg::fx_t z;
  } quat_t;

  typedef struct packed {
    quat_t q;
    logic  ovf;
  } quat_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [qau_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [qau_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;

  quat_res_t predicted_quats[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        no_idle = 1'b0;

  quaternion_arithmetic_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp16(longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic quat_res_t quat_op(qau_pkg::func_t op, quat_t a, quat_t b);
    longint    av[4];
    longint    bv[4];
    longint    uv[3];
    longint    uuv[3];
    longint    r[4];
    int        j;
    int        k;
    bit        sat;
    quat_res_t res;
    av[0] = longint'($signed(a.w));
    av[1] = longint'($signed(a.x));
    av[2] = longint'($signed(a.y));
    av[3] = longint'($signed(a.z));
    bv[0] = longint'($signed(b.w));
    bv[1] = longint'($signed(b.x));
    bv[2] = longint'($signed(b.y));
    bv[3] = longint'($signed(b.z));
    sat = 1'b0;
    for (int i = 0; i < 4; i++) r[i] = 0;
    case (op)
      qau_pkg::FUNC_MUL: begin
        r[0] = clamp16((av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2] - av[3]*bv[3]) >>> FRAC, sat);
        r[1] = clamp16((av[0]*bv[1] + av[1]*bv[0] + av[2]*bv[3] - av[3]*bv[2]) >>> FRAC, sat);
        r[2] = clamp16((av[0]*bv[2] + av[2]*bv[0] + av[3]*bv[1] - av[1]*bv[3]) >>> FRAC, sat);
        r[3] = clamp16((av[0]*bv[3] + av[3]*bv[0] + av[1]*bv[2] - av[2]*bv[1]) >>> FRAC, sat);
      end
      qau_pkg::FUNC_ROT: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          uv[i] = clamp16((av[1+j]*bv[1+k] - av[1+k]*bv[1+j]) >>> FRAC, sat);
        end
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          uuv[i] = clamp16((av[1+j]*uv[k] - av[1+k]*uv[j]) >>> FRAC, sat);
        end
        for (int i = 0; i < 3; i++)
          r[i+1] = clamp16(bv[i+1] + 2 * (((av[0]*uv[i]) >>> FRAC) + uuv[i]), sat);
      end
      qau_pkg::FUNC_CONJ: begin
        r[0] = av[0];
        for (int i = 0; i < 3; i++) r[i+1] = clamp16(-av[i+1], sat);
      end
      default: begin
      end
    endcase
    res.q.w = r[0][15:0];
    res.q.x = r[1][15:0];
    res.q.y = r[2][15:0];
    res.q.z = r[3][15:0];
    res.ovf = sat;
    return res;
  endfunction

  function automatic quat_t mk_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = qau_pkg::fx_t'(w);
    q.x = qau_pkg::fx_t'(x);
    q.y = qau_pkg::fx_t'(y);
    q.z = qau_pkg::fx_t'(z);
    return q;
  endfunction

  function automatic qau_pkg::fx_t rand_fx(int mag);
    int r;
    r = int'($urandom_range(0, 99));
    if (mag == 0) begin
      if (r < 4) return qau_pkg::fx_t'(-32768);
      if (r < 8) return qau_pkg::fx_t'(32767);
      return qau_pkg::fx_t'($urandom);
    end
    return qau_pkg::fx_t'(int'($urandom_range(0, 2 * mag)) - mag);
  endfunction

  function automatic quat_t rand_quat(int mag);
    return mk_quat(rand_fx(mag), rand_fx(mag), rand_fx(mag), rand_fx(mag));
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (no_idle || r < 60) return 0;
    if (r < 94) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 24));
  endfunction

  function automatic qau_pkg::func_t rand_func();
    return qau_pkg::func_t'($urandom_range(0, 3));
  endfunction

  task automatic push_quat_word(qau_pkg::func_t op, quat_t a, quat_t b);
    int gap;
    in_tuser  <= op;
    in_tdata  <= {b.z, b.y, b.x, b.w, a.z, a.y, a.x, a.w};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted_quats.push_back(quat_op(op, a, b));
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (predicted_quats.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_quat_word();
    quat_res_t want;
    quat_t     got;
    if (predicted_quats.size() == 0) begin
      $error("unexpected result word: tdata %h tuser %b", out_tdata, out_tuser);
      mismatches++;
      return;
    end
    want = predicted_quats.pop_front();
    got  = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48]};
    compare_field("r_w", int'($signed(want.q.w)), int'($signed(got.w)));
    compare_field("r_x", int'($signed(want.q.x)), int'($signed(got.x)));
    compare_field("r_y", int'($signed(want.q.y)), int'($signed(got.y)));
    compare_field("r_z", int'($signed(want.q.z)), int'($signed(got.z)));
    compare_field("overflow", int'(want.ovf), int'(out_tuser));
  endtask

  always @(posedge clk) begin
    int g;
    if (rst_n && out_tvalid && out_tready) check_quat_word();
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left = g - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic test_directed_cases();
    quat_t id;
    id = mk_quat(4096, 0, 0, 0);
    push_quat_word(qau_pkg::FUNC_MUL, id, id);
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(0, 0, 0, 0),
                   mk_quat(32767, 32767, -32768, 32767));
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(32767, 32767, 32767, 32767),
                   mk_quat(32767, 32767, 32767, 32767));
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(-32768, -32768, -32768, -32768),
                   mk_quat(-32768, -32768, -32768, -32768));
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(32767, -32768, 32767, -32768),
                   mk_quat(-32768, 32767, -32768, 32767));
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(1, 0, 0, 0), mk_quat(-1, -1, 1, -1));
    push_quat_word(qau_pkg::FUNC_MUL, mk_quat(2048, 1024, -512, 300),
                   mk_quat(100, -4096, 2000, -3000));
    push_quat_word(qau_pkg::FUNC_ROT, id, mk_quat(0, 4096, -8192, 12288));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(2896, 0, 0, 2896), mk_quat(0, 4096, 0, 0));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(2896, 2896, 0, 0),
                   mk_quat(-32768, 0, 4096, -4096));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(32767, 32767, 32767, 32767),
                   mk_quat(32767, 32767, -32768, 32767));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(-32768, -32768, -32768, -32768),
                   mk_quat(-32768, -32768, -32768, -32768));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(0, -32768, 32767, -32768),
                   mk_quat(0, 32767, 32767, 32767));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(-1, 1, -1, 1), mk_quat(32767, -1, 1, -1));
    push_quat_word(qau_pkg::FUNC_ROT, mk_quat(4096, 0, 0, 0), mk_quat(0, 32767, -32768, 0));
    push_quat_word(qau_pkg::FUNC_CONJ, mk_quat(1, 2, 3, 4), mk_quat(0, 0, 0, 0));
    push_quat_word(qau_pkg::FUNC_CONJ, mk_quat(-32768, -32768, -32768, -32768),
                   mk_quat(32767, 32767, 32767, 32767));
    push_quat_word(qau_pkg::FUNC_CONJ, mk_quat(32767, 32767, 32767, 32767),
                   mk_quat(-32768, -32768, -32768, -32768));
    push_quat_word(qau_pkg::FUNC_CONJ, mk_quat(0, 0, 0, 0),
                   mk_quat(12345, -4321, 777, -9999));
    push_quat_word(qau_pkg::FUNC_CONJ, mk_quat(-5, -32768, 0, 32767), mk_quat(0, 0, 0, 0));
  endtask

  task automatic test_random_full_range(int count);
    repeat (count) push_quat_word(rand_func(), rand_quat(0), rand_quat(0));
  endtask

  task automatic test_random_unit_scale(int count);
    int a_mag;
    int b_mag;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: a_mag = 1024;
        1: a_mag = 4096;
        2: a_mag = 8192;
        default: a_mag = 64;
      endcase
      b_mag = ($urandom_range(0, 1) == 0) ? 4096 : 16384;
      push_quat_word(rand_func(), rand_quat(a_mag), rand_quat(b_mag));
    end
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) push_quat_word(rand_func(), rand_quat(4096), rand_quat(0));
    no_idle = 1'b0;
  endtask

  task automatic test_pause_then_resume(int count);
    repeat (count / 2) push_quat_word(rand_func(), rand_quat(4096), rand_quat(8192));
    drain_results();
    repeat (count - count / 2) push_quat_word(rand_func(), rand_quat(0), rand_quat(4096));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_full_range(250);
    test_random_unit_scale(250);
    test_back_to_back(120);
    test_pause_then_resume(100);
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/qau_pkg.sv
hdl/qau_cross.sv
hdl/quaternion_arithmetic_unit.sv
bench/testbench.sv
